/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the console rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("assertion failed");

`endif

/* rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// constants and types for the text console writer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int ADDR_W = 11;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  typedef logic [ADDR_W-1:0] cell_addr_t;
  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [1:0]        opcode_t;

  localparam opcode_t OP_PUT   = 2'd0;
  localparam opcode_t OP_CLEAR = 2'd1;
  localparam opcode_t OP_READ  = 2'd2;

  localparam logic [7:0] ATTR_RESET = 8'h0F;
  localparam logic [7:0] CHAR_BLANK = 8'h20;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

endpackage

`default_nettype wire

/* rtl/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/text_console_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_console_writer_unit
// 80 x 25 text console: character put, screen clear and cell read
// ----------------------------------------------------------------------------
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+-------------------------
//  input    | in_opcode in_char_code in_cell_index   | start & !busy
//  result   | out_cursor_location out_cell_word      | out_valid, one cycle
//           | out_scrolled                           |
//  config   | cfg_text_attribute                     | cfg_valid & cfg_ready
//
//  put runs through the put and response states, read through read-wait and
//  response; opcode 3 and a read past the last cell go straight to response
//  clear walks the cell ram once; a put that scrolls adds a copy sweep (one
//  ram read and one ram write per cycle through the single read port)
//  after reset a clearing pass over every cell runs with busy high
//  the receiver cannot stall: each result is shown for exactly one cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module text_console_writer_unit (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output      logic                   busy,
  input  wire tcw_pkg::opcode_t       in_opcode,
  input  wire logic [7:0]             in_char_code,
  input  wire tcw_pkg::cell_addr_t    in_cell_index,
  output      logic                   out_valid,
  output      tcw_pkg::cell_addr_t    out_cursor_location,
  output      tcw_pkg::cell_t         out_cell_word,
  output      logic                   out_scrolled,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [7:0]             cfg_text_attribute
);

  import tcw_pkg::*;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_PUT    = 3'd2;
  localparam logic [2:0] ST_FILL   = 3'd3;
  localparam logic [2:0] ST_SCROLL = 3'd4;
  localparam logic [2:0] ST_RDWAIT = 3'd5;
  localparam logic [2:0] ST_RESP   = 3'd6;

  localparam cell_addr_t LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam cell_addr_t COPY_CELLS = ADDR_W'(CELLS - COLUMNS);
  localparam cell_addr_t END_SCROLL = ADDR_W'(CELLS);

  logic [2:0]       state_r, state_nxt;
  cell_addr_t       cnt_r, cnt_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [7:0]       attr_r;
  opcode_t          op_r;
  logic [7:0]       char_r;
  cell_t            word_r, word_nxt;
  logic             scrolled_r, scrolled_nxt;

  logic             accept;
  cell_addr_t       cursor_loc;
  cell_t            blank;

  logic             ram_we, ram_re;
  cell_addr_t       ram_waddr, ram_raddr;
  cell_t            ram_wdata, ram_rdata;

  logic [COL_W:0]   col_tmp;
  logic [COL_W:0]   col_tab;
  logic [ROW_W:0]   row_tmp;
  logic             printable;
  logic [ADDR_W:0]  scroll_src;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = !busy && !start;
  assign blank     = {attr_r, CHAR_BLANK};

  assign cursor_loc = ADDR_W'(ADDR_W'(row_r) * ADDR_W'(COLUMNS)) + ADDR_W'(col_r);

  assign out_valid           = (state_r == ST_RESP);
  assign out_cursor_location = cursor_loc;
  assign out_cell_word       = word_r;
  assign out_scrolled        = scrolled_r;

  assign printable  = !char_r[7] && (char_r >= CHAR_BLANK);
  assign col_tab    = {1'b0, col_r} + (COL_W+1)'(8);
  assign scroll_src = {1'b0, cnt_r} + (ADDR_W+1)'(COLUMNS);

  // cursor movement for one put
  always_comb begin
    col_tmp = {1'b0, col_r};
    row_tmp = {1'b0, row_r};
    case (char_r)
      CHAR_BS: begin
        if (col_r != '0) begin
          col_tmp = {1'b0, col_r} - (COL_W+1)'(1);
        end
      end
      CHAR_TAB: begin
        col_tmp = {col_tab[COL_W:3], 3'b000};
      end
      CHAR_CR: begin
        col_tmp = '0;
      end
      CHAR_LF: begin
        col_tmp = '0;
        row_tmp = {1'b0, row_r} + (ROW_W+1)'(1);
      end
      default: begin
        if (printable) begin
          col_tmp = {1'b0, col_r} + (COL_W+1)'(1);
        end
      end
    endcase
    if (col_tmp >= (COL_W+1)'(COLUMNS)) begin
      col_tmp = '0;
      row_tmp = row_tmp + (ROW_W+1)'(1);
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    word_nxt     = word_r;
    scrolled_nxt = scrolled_r;
    ram_we       = 1'b0;
    ram_waddr    = cnt_r;
    ram_wdata    = blank;
    ram_re       = 1'b0;
    ram_raddr    = in_cell_index;
    unique case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {ATTR_RESET, CHAR_BLANK};
        cnt_nxt   = cnt_r + ADDR_W'(1);
        if (cnt_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          word_nxt     = '0;
          scrolled_nxt = 1'b0;
          cnt_nxt      = '0;
          case (in_opcode)
            OP_PUT:   state_nxt = ST_PUT;
            OP_CLEAR: state_nxt = ST_FILL;
            OP_READ: begin
              if (in_cell_index < ADDR_W'(CELLS)) begin
                ram_re    = 1'b1;
                state_nxt = ST_RDWAIT;
              end else begin
                state_nxt = ST_RESP;
              end
            end
            default:  state_nxt = ST_RESP;
          endcase
        end
      end
      ST_PUT: begin
        ram_we    = printable;
        ram_waddr = cursor_loc;
        ram_wdata = {attr_r, char_r};
        col_nxt   = col_tmp[COL_W-1:0];
        if (row_tmp >= (ROW_W+1)'(ROWS)) begin
          row_nxt      = ROW_W'(ROWS - 1);
          scrolled_nxt = 1'b1;
          state_nxt    = ST_SCROLL;
        end else begin
          row_nxt   = row_tmp[ROW_W-1:0];
          state_nxt = ST_RESP;
        end
      end
      ST_FILL: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + ADDR_W'(1);
        if (cnt_r == LAST_CELL) begin
          col_nxt   = '0;
          row_nxt   = '0;
          state_nxt = ST_RESP;
        end
      end
      ST_SCROLL: begin
        // read one line ahead, write the cell read in the previous cycle
        ram_re    = (cnt_r < COPY_CELLS);
        ram_raddr = scroll_src[ADDR_W-1:0];
        ram_we    = (cnt_r != '0);
        ram_waddr = cnt_r - ADDR_W'(1);
        ram_wdata = (cnt_r <= COPY_CELLS) ? ram_rdata : blank;
        cnt_nxt   = cnt_r + ADDR_W'(1);
        if (cnt_r == END_SCROLL) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RDWAIT: begin
        word_nxt  = ram_rdata;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      cnt_r      <= '0;
      col_r      <= '0;
      row_r      <= '0;
      attr_r     <= ATTR_RESET;
      scrolled_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      scrolled_r <= scrolled_nxt;
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_text_attribute;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (accept) begin
      op_r   <= in_opcode;
      char_r <= in_char_code;
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
  `ASSERT_NEXT(a_resp_idle, clk, rst_n, out_valid, !busy)
  `ASSERT_IMPL(a_loc_range, clk, rst_n, out_valid, out_cursor_location < ADDR_W'(CELLS))
  `ASSERT_IMPL(a_scroll_row, clk, rst_n, out_valid && out_scrolled,
               row_r == ROW_W'(ROWS - 1) && op_r == OP_PUT)

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives put, clear and read commands into the text console writer, keeps its
// own copy of the screen and cursor, and checks every result word against it
// across several attribute settings and sender idling rates
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import tcw_pkg::*;

  localparam opcode_t    OP_UNUSED           = 2'd3;
  localparam logic [7:0] CHAR_NUL            = 8'h00;
  localparam logic [7:0] CHAR_LAST_CTRL      = 8'h1F;
  localparam logic [7:0] CHAR_LAST_PRINTABLE = 8'h7F;
  localparam logic [7:0] CHAR_HIGH_FIRST     = 8'h80;
  localparam logic [7:0] CHAR_HIGH_LAST      = 8'hFF;
  localparam logic [7:0] ATTR_ALL_CLEAR      = 8'h00;
  localparam logic [7:0] ATTR_ALL_SET        = 8'hFF;
  localparam logic [7:0] ATTR_YELLOW_ON_BLUE = 8'h1E;
  localparam int         MAX_INDEX           = 2047;
  localparam int         CYCLE_LIMIT         = 10_000_000;

  typedef struct {
    cell_addr_t cursor;
    cell_t      word;
    logic       scrolled;
  } console_result_t;

  class console_scoreboard;
    cell_t            screen [CELLS];
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [7:0]       attribute;
    console_result_t  pending [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      scrolls;

    function new();
      attribute = ATTR_RESET;
      blank_all();
      col = '0;
      row = '0;
    endfunction

    function void blank_all();
      foreach (screen[i]) screen[i] = {attribute, CHAR_BLANK};
    endfunction

    function void report(string what);
      $display("testbench: mismatch: %s", what);
      errors++;
    endfunction

    function void set_attribute(logic [7:0] value);
      attribute = value;
    endfunction

    function logic put_char(logic [7:0] ch);
      int unsigned at;
      if (ch == CHAR_BS) begin
        if (col != 0) col = col - 1'b1;
      end else if (ch == CHAR_TAB) begin
        col = {col[COL_W-1:3] + 1'b1, 3'b000};
      end else if (ch == CHAR_CR) begin
        col = '0;
      end else if (ch == CHAR_LF) begin
        col = '0;
        row = row + 1'b1;
      end else if (ch >= CHAR_BLANK && ch <= CHAR_LAST_PRINTABLE) begin
        at = row * COLUMNS + col;
        if (at < CELLS) screen[at] = {attribute, ch};
        col = col + 1'b1;
      end
      if (col >= COLUMNS) begin
        col = '0;
        row = row + 1'b1;
      end
      if (row < ROWS) return 1'b0;
      // move every line up one and blank the bottom line
      for (int i = 0; i + COLUMNS < CELLS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {attribute, CHAR_BLANK};
      row = ROW_W'(ROWS - 1);
      return 1'b1;
    endfunction

    function void note_item(opcode_t op, logic [7:0] ch, cell_addr_t idx);
      console_result_t want;
      want.word     = '0;
      want.scrolled = 1'b0;
      case (op)
        OP_PUT: want.scrolled = put_char(ch);
        OP_CLEAR: begin
          blank_all();
          col = '0;
          row = '0;
        end
        OP_READ: if (idx < CELLS) want.word = screen[idx];
        default: ;
      endcase
      want.cursor = cell_addr_t'(row * COLUMNS + col);
      pending.push_back(want);
    endfunction

    task check_result(cell_addr_t cursor, cell_t word, logic scrolled);
      console_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing outstanding, cursor %0d", cursor));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.scrolled) scrolls++;
      if (cursor !== want.cursor)
        report($sformatf("cursor %0d, wanted %0d", cursor, want.cursor));
      if (word !== want.word)
        report($sformatf("cell word %04h, wanted %04h", word, want.word));
      if (scrolled !== want.scrolled)
        report($sformatf("scrolled %b, wanted %b", scrolled, want.scrolled));
    endtask

    function void check_leftover();
      if (pending.size() != 0)
        report($sformatf("%0d results never arrived", pending.size()));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  opcode_t    in_opcode = OP_PUT;
  logic [7:0] in_char_code = 8'h00;
  cell_addr_t in_cell_index = '0;
  logic       out_valid;
  cell_addr_t out_cursor_location;
  cell_t      out_cell_word;
  logic       out_scrolled;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_text_attribute = 8'h00;

  console_scoreboard sb = new();
  int unsigned       items_sent = 0;
  int unsigned       cycle_count = 0;
  logic [7:0]        random_attr;

  always #4 clk = ~clk;

  text_console_writer_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_char_code        (in_char_code),
    .in_cell_index       (in_cell_index),
    .out_valid           (out_valid),
    .out_cursor_location (out_cursor_location),
    .out_cell_word       (out_cell_word),
    .out_scrolled        (out_scrolled),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_text_attribute  (cfg_text_attribute)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_cursor_location, out_cell_word, out_scrolled);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: timed out after %0d cycles", cycle_count);
    $display("testbench: done, errors");
    $finish;
  end

  task automatic send_item(input opcode_t op, input logic [7:0] ch, input cell_addr_t idx,
                           input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_opcode     <= op;
    in_char_code  <= ch;
    in_cell_index <= idx;
    do @(posedge clk); while (busy);
    // transfer taken at this edge
    sb.note_item(op, ch, idx);
    items_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    cfg_valid          <= 1'b1;
    cfg_text_attribute <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_attribute(value);
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return 8'($urandom_range(CHAR_LAST_PRINTABLE, CHAR_BLANK));
    if (roll < 68) return CHAR_LF;
    if (roll < 76) return CHAR_TAB;
    if (roll < 81) return CHAR_CR;
    if (roll < 88) return CHAR_BS;
    if (roll < 94) return 8'($urandom_range(CHAR_LAST_CTRL, CHAR_NUL));
    return 8'($urandom_range(CHAR_HIGH_LAST, CHAR_HIGH_FIRST));
  endfunction

  task automatic run_random(input int count, input int idle_pct);
    int unsigned roll;
    opcode_t     op;
    cell_addr_t  idx;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 80) op = OP_PUT;
      else if (roll < 98) op = OP_READ;
      else if (roll < 99) op = OP_CLEAR;
      else op = OP_UNUSED;
      if ($urandom_range(9) == 0) idx = cell_addr_t'($urandom_range(MAX_INDEX, CELLS));
      else idx = cell_addr_t'($urandom_range(CELLS - 1));
      send_item(op, pick_char(), idx, idle_pct);
      // now and then hold off until every result is back
      if ($urandom_range(59) == 0) drain_results();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset screen, cursor moves and the odd bytes
    send_item(OP_READ, CHAR_NUL, cell_addr_t'(0), 12);
    send_item(OP_READ, CHAR_HIGH_LAST, cell_addr_t'(CELLS - 1), 12);
    send_item(OP_READ, CHAR_NUL, cell_addr_t'(CELLS), 12);
    send_item(OP_READ, CHAR_NUL, cell_addr_t'(MAX_INDEX), 12);
    send_item(OP_UNUSED, CHAR_HIGH_LAST, cell_addr_t'(MAX_INDEX), 12);
    send_item(OP_PUT, CHAR_BS, '0, 12);
    send_item(OP_PUT, CHAR_BLANK, '0, 12);
    send_item(OP_PUT, CHAR_LAST_PRINTABLE, '0, 12);
    send_item(OP_PUT, 8'h41, '0, 12);
    send_item(OP_PUT, CHAR_BS, '0, 12);
    send_item(OP_PUT, CHAR_TAB, '0, 12);
    send_item(OP_PUT, CHAR_TAB, '0, 12);
    send_item(OP_PUT, CHAR_CR, '0, 12);
    send_item(OP_PUT, CHAR_NUL, '0, 12);
    send_item(OP_PUT, CHAR_LAST_CTRL, '0, 12);
    send_item(OP_PUT, CHAR_HIGH_FIRST, '0, 12);
    send_item(OP_PUT, CHAR_HIGH_LAST, '0, 12);
    send_item(OP_READ, CHAR_NUL, cell_addr_t'(1), 12);
    send_item(OP_PUT, CHAR_LF, '0, 12);
    send_item(OP_PUT, 8'h55, '0, 12);
    send_item(OP_READ, CHAR_NUL, cell_addr_t'(COLUMNS), 12);
    send_item(OP_CLEAR, CHAR_HIGH_LAST, cell_addr_t'(MAX_INDEX), 12);
    send_item(OP_READ, CHAR_NUL, cell_addr_t'(2), 12);

    run_random(200, 12);
    drain_results();
    write_attribute(ATTR_ALL_CLEAR);
    run_random(100, 84);
    drain_results();
    write_attribute(ATTR_ALL_SET);
    run_random(100, 84);
    drain_results();
    random_attr = 8'($urandom_range(254, 1));
    write_attribute(random_attr);
    run_random(100, 0);
    drain_results();
    write_attribute(ATTR_YELLOW_ON_BLUE);
    run_random(100, 0);
    drain_results();
    repeat (16) @(posedge clk);
    sb.check_leftover();

    $display("testbench: %0d commands sent, %0d results checked, %0d of them scrolled",
             items_sent, sb.checked, sb.scrolls);
    $display("testbench: attributes 0f, 00, ff, %02h, 1e; sender idle 12, 84, 0 per cent",
             random_attr);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
